// ===== hw/rtl/prrs_pkg.sv =====
// Shared types and codes for the priority round-robin scheduler.
package prrs_pkg;

   localparam int unsigned IdWidth    = 16;
   localparam int unsigned PriWidth   = 3;
   localparam int unsigned BurstWidth = 3;

   typedef enum logic [1:0] {
      MODE_TICK = 2'd0,
      MODE_ADD  = 2'd1,
      MODE_SET  = 2'd2,
      MODE_NOP  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [IdWidth-1:0]    id;
      logic [PriWidth-1:0]   pri;
      logic [BurstWidth-1:0] burst;
   } entry_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_AGE_RD,
      SEQ_AGE_WR,
      SEQ_SORT_RD,
      SEQ_SORT_CMP,
      SEQ_SORT_WR,
      SEQ_SEL_RD,
      SEQ_SERVE,
      SEQ_REM_RD,
      SEQ_REM_WR,
      SEQ_FIND_RD,
      SEQ_FIND_CMP,
      SEQ_DONE
   } seq_state_type;

endpackage

// ===== hw/rtl/prrs_table_ram.sv =====
// Task table storage: one write port, one registered read port.
module prrs_table_ram #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  prrs_pkg::entry_type wr_data,
   input  logic [AW-1:0]       rd_addr,
   output prrs_pkg::entry_type rd_data
);

   prrs_pkg::entry_type mem [DEPTH];
   prrs_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/priority_round_robin_scheduler_unit.sv =====
// Top level of the priority round-robin scheduler with aging.
// One request at a time: a sequencer walks the task table held in a RAM with a registered read
// port, one read and at most one write per cycle. A no-op, a tick on an empty table and an add
// on a full table go straight to the result. A tick reads entry 0, then the entry at the cursor,
// and reads entry 0 again when the cursor falls back to the head of the top group. A finished
// task is removed by moving each entry behind it one place forward. An aging step moves the
// last entry one level up and inserts it anew; an add inserts the new entry. Set-priority
// searches the table entry by entry, then re-sorts the whole table by insertion from the second
// entry on. A result sits in an output register, and the next request is taken the cycle after
// it is passed on. The table needs no clearing after reset.
module priority_round_robin_scheduler_unit #(
   parameter int unsigned TABLE_DEPTH     = 16,
   parameter int unsigned PRIORITY_LEVELS = 5,
   parameter int unsigned MAX_BURST       = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] mode, [4:2] priority_req, [7:5] burst, [23:8] task_id
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [17:2] served_id, [18] completed, [23:19] task_count
   output logic [23:0] rsp_tdata
);

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned IW = prrs_pkg::IdWidth;
   localparam int unsigned PW = prrs_pkg::PriWidth;
   localparam int unsigned BW = prrs_pkg::BurstWidth;
   localparam logic [PW-1:0] PriMax = PW'(PRIORITY_LEVELS - 1);
   localparam logic [BW-1:0] BurstMax = BW'(MAX_BURST);
   localparam logic [BW-1:0] BurstSub = BW'(MAX_BURST - 1);
   localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

   prrs_pkg::seq_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] cursor_ff, cursor_in;
   logic [CW-1:0] aging_ff, aging_in;
   logic [IW-1:0] next_id_ff, next_id_in;
   // sort: i outer index, j insertion point, key held
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   prrs_pkg::entry_type key_ff, key_in;
   prrs_pkg::entry_type hold_ff, hold_in;
   logic [PW-1:0] pri0_ff, pri0_in;
   prrs_pkg::mode_type mode_ff, mode_in;
   logic [PW-1:0] preq_ff, preq_in;
   logic [IW-1:0] want_ff, want_in;
   logic          rv_ff, rv_in;
   logic [1:0]    st_ff, st_in;
   logic [IW-1:0] sid_ff, sid_in;
   logic          done_ff, done_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   prrs_pkg::entry_type wr_data, rd_data;

   prrs_table_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   logic [PW-1:0] pri_clip;
   logic [BW-1:0] burst_clip;
   logic [BW-1:0] dec_burst;
   logic [PW-1:0] req_pri;
   logic [BW-1:0] req_burst;

   assign req_pri    = req_tdata[4:2];
   assign req_burst  = req_tdata[7:5];
   assign pri_clip   = (preq_ff > PriMax) ? PriMax : preq_ff;
   assign burst_clip = (req_burst > BurstMax) ? BurstSub : req_burst;
   assign dec_burst  = (rd_data.burst != '0) ? rd_data.burst - 1'b1 : '0;

   assign req_tready = (state_ff == prrs_pkg::SEQ_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {count_ff, done_ff, sid_ff, st_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= prrs_pkg::SEQ_IDLE;
         count_ff   <= '0;
         cursor_ff  <= '0;
         aging_ff   <= '0;
         next_id_ff <= '0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cursor_ff  <= cursor_in;
         aging_ff   <= aging_in;
         next_id_ff <= next_id_in;
         rv_ff      <= rv_in;
      end
      i_ff    <= i_in;
      j_ff    <= j_in;
      key_ff  <= key_in;
      hold_ff <= hold_in;
      pri0_ff <= pri0_in;
      mode_ff <= mode_in;
      preq_ff <= preq_in;
      want_ff <= want_in;
      st_ff   <= st_in;
      sid_ff  <= sid_in;
      done_ff <= done_in;
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      cursor_in  = cursor_ff;
      aging_in   = aging_ff;
      next_id_in = next_id_ff;
      rv_in      = rv_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      key_in     = key_ff;
      hold_in    = hold_ff;
      pri0_in    = pri0_ff;
      mode_in    = mode_ff;
      preq_in    = preq_ff;
      want_in    = want_ff;
      st_in      = st_ff;
      sid_in     = sid_ff;
      done_in    = done_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = key_ff;
      rd_addr    = '0;

      if (rv_ff && rsp_tready) begin
         rv_in = 1'b0;
      end

      unique case (state_ff)
         prrs_pkg::SEQ_IDLE: begin
            if (req_tvalid && req_tready) begin
               mode_in = prrs_pkg::mode_type'(req_tdata[1:0]);
               preq_in = req_pri;
               want_in = req_tdata[23:8];
               st_in   = prrs_pkg::ST_OK;
               sid_in  = '0;
               done_in = 1'b0;
               unique case (prrs_pkg::mode_type'(req_tdata[1:0]))
                  prrs_pkg::MODE_TICK: begin
                     if (count_ff == '0) begin
                        st_in    = prrs_pkg::ST_EMPTY;
                        state_in = prrs_pkg::SEQ_DONE;
                     end else if (aging_ff >= count_ff) begin
                        state_in = prrs_pkg::SEQ_AGE_RD;
                     end else begin
                        state_in = prrs_pkg::SEQ_SEL_RD;
                     end
                  end
                  prrs_pkg::MODE_ADD: begin
                     if (count_ff >= DepthC) begin
                        st_in    = prrs_pkg::ST_FULL;
                        state_in = prrs_pkg::SEQ_DONE;
                     end else begin
                        // new entry goes at the end, then one insertion step
                        key_in.id    = next_id_ff;
                        key_in.pri   = (req_pri > PriMax) ? PriMax : req_pri;
                        key_in.burst = burst_clip;
                        sid_in       = next_id_ff;
                        next_id_in   = next_id_ff + 1'b1;
                        i_in         = count_ff;
                        j_in         = count_ff;
                        count_in     = count_ff + 1'b1;
                        state_in     = (count_ff == '0) ? prrs_pkg::SEQ_SORT_WR
                                                        : prrs_pkg::SEQ_SORT_RD;
                     end
                  end
                  prrs_pkg::MODE_SET: begin
                     i_in     = '0;
                     state_in = (count_ff == '0) ? prrs_pkg::SEQ_DONE
                                                 : prrs_pkg::SEQ_FIND_RD;
                     if (count_ff == '0) begin
                        st_in = prrs_pkg::ST_NOT_FOUND;
                     end
                  end
                  default: begin
                     state_in = prrs_pkg::SEQ_DONE;
                  end
               endcase
            end
         end

         prrs_pkg::SEQ_AGE_RD: begin
            rd_addr  = AW'(count_ff - 1'b1);
            state_in = prrs_pkg::SEQ_AGE_WR;
         end

         prrs_pkg::SEQ_AGE_WR: begin
            // last entry moves one level up; only it can be out of order
            key_in = rd_data;
            if (rd_data.pri != '0) begin
               key_in.pri = rd_data.pri - 1'b1;
            end
            aging_in = '0;
            i_in     = count_ff - 1'b1;
            j_in     = count_ff - 1'b1;
            state_in = (count_ff == CW'(1)) ? prrs_pkg::SEQ_SORT_WR
                                            : prrs_pkg::SEQ_SORT_RD;
         end

         prrs_pkg::SEQ_SORT_RD: begin
            rd_addr  = AW'(j_ff - 1'b1);
            state_in = prrs_pkg::SEQ_SORT_CMP;
         end

         prrs_pkg::SEQ_SORT_CMP: begin
            if (rd_data.pri > key_ff.pri) begin
               wr_en   = 1'b1;
               wr_addr = AW'(j_ff);
               wr_data = rd_data;
               j_in    = j_ff - 1'b1;
               state_in = (j_ff == CW'(1)) ? prrs_pkg::SEQ_SORT_WR
                                           : prrs_pkg::SEQ_SORT_RD;
            end else begin
               state_in = prrs_pkg::SEQ_SORT_WR;
            end
         end

         prrs_pkg::SEQ_SORT_WR: begin
            wr_en   = 1'b1;
            wr_addr = AW'(j_ff);
            wr_data = key_ff;
            // set-priority needs a full pass for the moved entry to settle;
            // a single-key insertion from index i suffices when i is the only misfit
            if (mode_ff == prrs_pkg::MODE_SET && (i_ff + 1'b1) < count_ff) begin
               i_in     = i_ff + 1'b1;
               j_in     = i_ff + 1'b1;
               state_in = prrs_pkg::SEQ_REM_RD;
               hold_in.id = '0;
            end else if (mode_ff == prrs_pkg::MODE_TICK) begin
               state_in = prrs_pkg::SEQ_SEL_RD;
            end else begin
               state_in = prrs_pkg::SEQ_DONE;
            end
         end

         prrs_pkg::SEQ_SEL_RD: begin
            rd_addr  = '0;
            state_in = prrs_pkg::SEQ_SERVE;
         end

         prrs_pkg::SEQ_SERVE: begin
            if (mode_ff == prrs_pkg::MODE_SET) begin
               // fetched next key for the set-priority sort pass
               key_in   = rd_data;
               state_in = prrs_pkg::SEQ_SORT_RD;
            end else if (hold_ff.id == IW'(1)) begin
               // first read was entry 0: latch top priority, then read cursor
               pri0_in    = rd_data.pri;
               hold_in.id = IW'(2);
               if (CW'(cursor_ff) >= count_ff) begin
                  cursor_in = '0;
               end
               rd_addr  = (CW'(cursor_ff) >= count_ff) ? '0 : cursor_ff;
               state_in = prrs_pkg::SEQ_SERVE;
            end else begin
               hold_in.id = '0;
               if (rd_data.pri != pri0_ff && cursor_ff != '0) begin
                  cursor_in  = '0;
                  rd_addr    = '0;
                  hold_in.id = IW'(2);
                  state_in   = prrs_pkg::SEQ_SERVE;
               end else begin
                  sid_in = rd_data.id;
                  if (aging_ff < DepthC) begin
                     aging_in = aging_ff + 1'b1;
                  end
                  if (dec_burst == '0) begin
                     done_in = 1'b1;
                     j_in    = CW'(cursor_ff);
                     state_in = prrs_pkg::SEQ_REM_RD;
                  end else begin
                     wr_en     = 1'b1;
                     wr_addr   = cursor_ff;
                     wr_data   = rd_data;
                     wr_data.burst = dec_burst;
                     cursor_in = cursor_ff + 1'b1;
                     state_in  = prrs_pkg::SEQ_DONE;
                  end
               end
            end
         end

         prrs_pkg::SEQ_REM_RD: begin
            if (mode_ff == prrs_pkg::MODE_SET) begin
               rd_addr  = AW'(i_ff);
               state_in = prrs_pkg::SEQ_SERVE;
            end else if ((j_ff + 1'b1) < count_ff) begin
               rd_addr  = AW'(j_ff + 1'b1);
               state_in = prrs_pkg::SEQ_REM_WR;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = prrs_pkg::SEQ_DONE;
            end
         end

         prrs_pkg::SEQ_REM_WR: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(j_ff);
            wr_data  = rd_data;
            j_in     = j_ff + 1'b1;
            state_in = prrs_pkg::SEQ_REM_RD;
         end

         prrs_pkg::SEQ_FIND_RD: begin
            rd_addr  = AW'(i_ff);
            state_in = prrs_pkg::SEQ_FIND_CMP;
         end

         prrs_pkg::SEQ_FIND_CMP: begin
            if (rd_data.id == want_ff) begin
               wr_en       = 1'b1;
               wr_addr     = AW'(i_ff);
               wr_data     = rd_data;
               wr_data.pri = pri_clip;
               // full insertion sort from index 1
               if (count_ff == CW'(1)) begin
                  state_in = prrs_pkg::SEQ_DONE;
               end else begin
                  i_in     = CW'(1);
                  j_in     = CW'(1);
                  state_in = prrs_pkg::SEQ_REM_RD;
               end
            end else if ((i_ff + 1'b1) < count_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = prrs_pkg::SEQ_FIND_RD;
            end else begin
               st_in    = prrs_pkg::ST_NOT_FOUND;
               state_in = prrs_pkg::SEQ_DONE;
            end
         end

         prrs_pkg::SEQ_DONE: begin
            rv_in    = 1'b1;
            state_in = prrs_pkg::SEQ_IDLE;
            if (mode_ff == prrs_pkg::MODE_ADD || mode_ff == prrs_pkg::MODE_SET) begin
               if (st_ff == prrs_pkg::ST_OK && mode_ff == prrs_pkg::MODE_SET) begin
                  sid_in = '0;
               end
            end
         end

         default: begin
            state_in = prrs_pkg::SEQ_IDLE;
         end
      endcase

      // tick selection sequencing: SEL_RD arms the two-read serve step
      if (state_ff == prrs_pkg::SEQ_SEL_RD) begin
         hold_in.id = IW'(1);
      end
      // empty tick still ages
      if (state_ff == prrs_pkg::SEQ_IDLE && req_tvalid && req_tready &&
          req_tdata[1:0] == prrs_pkg::MODE_TICK && count_ff == '0 && aging_ff < DepthC) begin
         aging_in = aging_ff + 1'b1;
      end
   end

endmodule

// ===== hw/rtl/prrs_checker.sv =====
// Port-level checks for the scheduler, bound to the top level.
module prrs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // result is held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");

   // no new request taken while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken with result pending");

   // a taken request keeps the input closed in the next cycle
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // task count never exceeds sixteen
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:19] <= 5'd16)
      else $error("task count out of range");

   // completed only with status ok
   a_done_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[18] |-> rsp_tdata[1:0] == 2'd0)
      else $error("completed with bad status");

endmodule

bind priority_round_robin_scheduler_unit prrs_checker u_prrs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
